// ----- hw/rtl/tspd_pkg.sv -----
// ----------------------------------------------------------------------------
// tspd_pkg: shared types and constants of the transport stream PID/PES demux
// Defines the result item layout, result kinds, input commands and the
// packet framing constants used by the core, its result queue and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tspd_pkg;

	// Packet framing.
	localparam logic [7:0]  SYNC_BYTE    = 8'h47;
	localparam int          PKT_BYTES    = 188;
	localparam logic [7:0]  PKT_LAST     = 8'(PKT_BYTES - 1);
	localparam logic [8:0]  PKT_BYTES_W  = 9'(PKT_BYTES);
	// Latest payload offset that still leaves room for a PES header.
	localparam logic [7:0]  PES_OFS_MAX  = 8'(PKT_BYTES - 14);
	localparam logic [12:0] PID_RESET    = 13'h0100;

	// Header flag bits kept between bytes.
	localparam int FLAG_START = 6;
	localparam int FLAG_ADAPT = 5;

	// Input command codes (carried on s_tuser).
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// Result kinds (carried on m_tuser).
	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_START   = 2'd1,
		KIND_PTS     = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	// One result item.
	typedef struct packed {
		kind_t       kind;
		logic        previous_complete;
		logic [32:0] timestamp;
		logic [7:0]  payload_byte;
	} res_t;

	// Results produced by one accepted input item, in delivery order.
	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} push_t;

	// Result queue depth; two free slots are needed to take an item.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

endpackage

`default_nettype wire

// ----- hw/rtl/ts_video_pid_pes_demux_core.sv -----
// ----------------------------------------------------------------------------
// ts_video_pid_pes_demux_core: transport stream PID filter and PES splitter
// Keeps the packets of one PID, validates PES starts and emits unit starts,
// timestamps and payload bytes of the open unit.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one transport stream byte per item on s_tdata with
// s_tuser low, or an end-of-stream command with s_tuser high. The master
// stream gives result items: m_tuser is the kind (payload, unit start,
// timestamp, stream ended), m_tdata holds the byte, the 33-bit timestamp and
// the previous-unit-complete flag. The cfg channel writes the 13-bit PID and
// is always ready; write it only while the block is idle.
// An accepted item writes its results into the result queue at the accepting
// edge. One item per cycle is sustained while that queue has room; an item
// yields zero, one or two results into a four-entry result queue, and
// s_tready stays high while that queue has room for two results.
// When the receiver stalls, the queue fills and s_tready drops until it
// drains. Reset clears the packet state, the queue and sets the PID to 0x100.
// After a bad sync byte or an end command the block reports the end once and
// then swallows every item without results until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ts_video_pid_pes_demux_core
	import tspd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
	input  wire logic        s_tuser,   // [0] command
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [7:0] payload_byte, [40:8] timestamp,
	                                    // [41] previous_complete, [47:42] zero
	output logic [1:0]       m_tuser,   // [1:0] kind
	// Configuration.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [12:0] cfg_data   // [12:0] video_pid
);

	logic [12:0] video_pid_q;
	logic [7:0]  pos_q,     pos_d;
	logic [7:0]  flags_q,   flags_d;
	logic        sel_q,     sel_d;
	logic [7:0]  ofs_q,     ofs_d;
	logic        pes_q,     pes_d;
	logic [7:0]  hlen_q,    hlen_d;
	logic        ptsp_q,    ptsp_d;
	logic [32:0] pts_q,     pts_d;
	logic        open_q,    open_d;
	logic        stopped_q, stopped_d;

	logic        acc;
	logic [7:0]  b;
	logic [7:0]  k;
	logic [8:0]  at;
	push_t       push;
	res_t        out_res;

	assign acc       = s_tvalid && s_tready;
	assign b         = s_tdata;
	assign k         = pos_q - ofs_q;
	assign at        = {1'b0, b} + 9'd5;
	assign cfg_ready = 1'b1;

	// Per-byte packet parsing and result generation.
	always_comb begin
		pos_d     = pos_q;
		flags_d   = flags_q;
		sel_d     = sel_q;
		ofs_d     = ofs_q;
		pes_d     = pes_q;
		hlen_d    = hlen_q;
		ptsp_d    = ptsp_q;
		pts_d     = pts_q;
		open_d    = open_q;
		stopped_d = stopped_q;
		push      = '0;
		push.r0.kind = KIND_PAYLOAD;
		push.r1.kind = KIND_PAYLOAD;
		if (acc && !stopped_q) begin
			if (s_tuser == CMD_END || (pos_q == '0 && b != SYNC_BYTE)) begin
				// Stream closes: report the end and stop.
				push.v0                   = 1'b1;
				push.r0.kind              = KIND_END;
				push.r0.previous_complete = open_q;
				open_d                    = 1'b0;
				stopped_d                 = 1'b1;
			end else begin
				pos_d = (pos_q == PKT_LAST) ? '0 : pos_q + 8'd1;
				if (pos_q == 8'd0) begin
					sel_d   = 1'b0;
					pes_d   = 1'b0;
					ptsp_d  = 1'b0;
					pts_d   = '0;
					hlen_d  = '0;
					ofs_d   = '0;
					flags_d = '0;
				end else if (pos_q == 8'd1) begin
					flags_d = b & 8'h5f;
				end else if (pos_q == 8'd2) begin
					sel_d = ({flags_q[4:0], b} == video_pid_q);
				end else if (pos_q == 8'd3) begin
					if (!b[4]) begin
						sel_d = 1'b0;
					end
					flags_d = (flags_q & 8'h40) | (b & 8'h20);
					ofs_d   = 8'd4;
				end else if (pos_q == 8'd4 && flags_q[FLAG_ADAPT]) begin
					// Adaptation field length; drop the packet if it overruns.
					if (at >= PKT_BYTES_W) begin
						sel_d = 1'b0;
						ofs_d = PKT_LAST;
					end else begin
						ofs_d = at[7:0];
					end
				end else if (sel_q && pos_q >= ofs_q) begin
					if (!flags_q[FLAG_START]) begin
						// Continuation payload of the open unit.
						if (open_q) begin
							push.v0              = 1'b1;
							push.r0.kind         = KIND_PAYLOAD;
							push.r0.payload_byte = b;
						end
					end else if (k == 8'd0) begin
						if (ofs_q > PES_OFS_MAX || b != 8'd0) begin
							sel_d = 1'b0;
						end
					end else if (k == 8'd1) begin
						if (b != 8'd0) begin
							sel_d = 1'b0;
						end
					end else if (k == 8'd2) begin
						// Start code complete: a new unit opens.
						if (b != 8'd1) begin
							sel_d = 1'b0;
						end else begin
							pes_d                     = 1'b1;
							push.v0                   = 1'b1;
							push.r0.kind              = KIND_START;
							push.r0.previous_complete = open_q;
							open_d                    = 1'b1;
						end
					end else if (pes_q) begin
						// PES header fields and the timestamp.
						case (k)
							8'd7:  ptsp_d = b[7];
							8'd8:  hlen_d = b;
							8'd9:  pts_d  = {b[3:1], 30'd0};
							8'd10: pts_d  = pts_q | {3'd0, b, 22'd0};
							8'd11: pts_d  = pts_q | {11'd0, b[7:1], 15'd0};
							8'd12: pts_d  = pts_q | {18'd0, b, 7'd0};
							8'd13: pts_d  = pts_q | {26'd0, b[7:1]};
							default: ;
						endcase
						if (k >= 8'd9 && (k - 8'd9) >= hlen_q) begin
							push.v0              = 1'b1;
							push.r0.kind         = KIND_PAYLOAD;
							push.r0.payload_byte = b;
						end
						if (k == 8'd13) begin
							if (push.v0) begin
								push.v1           = 1'b1;
								push.r1.kind      = KIND_PTS;
								push.r1.timestamp = ptsp_q ? pts_d : '0;
							end else begin
								push.v0           = 1'b1;
								push.r0.kind      = KIND_PTS;
								push.r0.timestamp = ptsp_q ? pts_d : '0;
							end
						end
					end
				end
			end
		end
	end

	// Parser state and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_pid_q <= PID_RESET;
			pos_q       <= '0;
			flags_q     <= '0;
			sel_q       <= 1'b0;
			ofs_q       <= '0;
			pes_q       <= 1'b0;
			hlen_q      <= '0;
			ptsp_q      <= 1'b0;
			pts_q       <= '0;
			open_q      <= 1'b0;
			stopped_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				video_pid_q <= cfg_data;
			end
			pos_q     <= pos_d;
			flags_q   <= flags_d;
			sel_q     <= sel_d;
			ofs_q     <= ofs_d;
			pes_q     <= pes_d;
			hlen_q    <= hlen_d;
			ptsp_q    <= ptsp_d;
			pts_q     <= pts_d;
			open_q    <= open_d;
			stopped_q <= stopped_d;
		end
	end

	// Result queue between the parser and the master stream.
	tspd_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tuser = out_res.kind;
	assign m_tdata = {6'd0, out_res.previous_complete, out_res.timestamp,
		out_res.payload_byte};

endmodule

`default_nettype wire

// ----- hw/rtl/tspd_res_fifo.sv -----
// ----------------------------------------------------------------------------
// tspd_res_fifo: result queue of the demux
// Takes up to two result items per cycle and hands out one per cycle on the
// master stream side when out_ready is high; reports room for two more items.
// ----------------------------------------------------------------------------
`default_nettype none

module tspd_res_fifo
	import tspd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_ready,
	output res_t       out_data
);

	res_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     cnt_q;
	logic             pop;
	logic [QAW:0]     n_push;
	logic [QAW-1:0]   wr_ptr1;

	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= (QAW+1)'(QDEPTH - 2));
	assign wr_ptr1   = wr_ptr_q + QAW'(1);

	// Number of items written this cycle; the second only follows the first.
	always_comb begin
		n_push = '0;
		if (push.v0 && push.v1) begin
			n_push = (QAW+1)'(2);
		end else if (push.v0) begin
			n_push = (QAW+1)'(1);
		end
	end

	// Storage writes.
	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.v0 && push.v1) begin
			mem_q[wr_ptr1] <= push.r1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[QAW-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			cnt_q <= cnt_q + n_push - (QAW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/tspd_checker.sv -----
// ----------------------------------------------------------------------------
// tspd_checker: port-level checks of the demux
// Watches the top-level ports for field consistency, stall behavior and
// silence after the stream has ended.
// ----------------------------------------------------------------------------
`default_nettype none

module tspd_checker
	import tspd_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	logic ended_q;

	// Set once the stream-ended item has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q <= 1'b0;
		end else if (m_tvalid && m_tready && m_tuser == KIND_END) begin
			ended_q <= 1'b1;
		end
	end

	// Nothing follows the stream-ended item.
	a_silent_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> !m_tvalid)
		else $error("result item after stream end");

	// Completion flag only on unit start and stream end items.
	a_prev_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_PAYLOAD || m_tuser == KIND_PTS) |-> !m_tdata[41])
		else $error("previous_complete set on payload or timestamp item");

	// Timestamp is zero outside timestamp items, byte is zero on start and end items.
	a_field_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_PTS |-> m_tdata[40:8] == 33'd0 &&
		(m_tuser == KIND_PAYLOAD || m_tdata[7:0] == 8'd0))
		else $error("unused result field not zero");

	// A stalled result item holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result item changed");

endmodule

bind ts_video_pid_pes_demux_core tspd_checker u_tspd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser)
);

`default_nettype wire

// ----- tb/tb_ts_video_pid_pes_demux_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ts_video_pid_pes_demux_core: self-checking bench of the PID/PES demux
// Feeds transport stream packets, directed ones and one random one, through the
// input stream while both sides idle at random outside one steady phase. A
// per-item model of the packet parser predicts every result item, and a scoreboard
// compares each delivered item field by field. The video PID is rewritten
// between phases, once in the middle of a packet, and the run ends by closing
// the stream and checking that nothing comes out after that.
// ----------------------------------------------------------------------------

module tb_ts_video_pid_pes_demux_core;
	import tspd_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PRINT_LIMIT   = 50;

	// One stream item as offered to the input side.
	typedef struct packed {
		logic       cmd;
		logic [7:0] data;
	} ts_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [12:0] cfg_data = 13'd0;

	logic        steady = 1'b0;
	int          mismatches = 0;
	int          quiet_cycles = 0;

	ts_item_t    byte_feed[$];
	res_t        due_results[$];
	logic [7:0]  pkt_bytes[PKT_BYTES];

	// Parser model state.
	logic [12:0] pid_model = PID_RESET;
	logic [7:0]  pkt_pos = 8'd0;
	logic [7:0]  hdr_flags = 8'd0;
	logic        pkt_keep = 1'b0;
	logic [7:0]  pay_ofs = 8'd0;
	logic        pes_ok = 1'b0;
	logic [7:0]  hdr_len = 8'd0;
	logic        has_pts = 1'b0;
	logic [32:0] pts_acc = 33'd0;
	logic        unit_is_open = 1'b0;
	logic        halted = 1'b0;

	ts_video_pid_pes_demux_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT) begin
			$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		end
	endtask

	task automatic push_result(input kind_t kind, input logic [7:0] data_b,
			input logic [32:0] ts, input logic prev);
		res_t r;
		r.kind = kind;
		r.payload_byte = data_b;
		r.timestamp = ts;
		r.previous_complete = prev;
		due_results.push_back(r);
	endtask

	// A bad sync byte or an end command closes the open unit and stops the block.
	task automatic close_stream();
		push_result(KIND_END, 8'd0, 33'd0, unit_is_open);
		unit_is_open = 1'b0;
		halted = 1'b1;
	endtask

	// Predicts the result items caused by one accepted stream item.
	task automatic demux_predict(input logic cmd, input logic [7:0] b);
		int p;
		int k;
		logic [12:0] pid;
		if (halted) begin
			return;
		end
		if (cmd == CMD_END) begin
			close_stream();
			return;
		end
		p = pkt_pos;
		if (p == 0 && b != SYNC_BYTE) begin
			close_stream();
			return;
		end
		pkt_pos = (p == PKT_LAST) ? 8'd0 : 8'(p + 1);

		if (p == 0) begin
			pkt_keep = 1'b0;
			pes_ok = 1'b0;
			has_pts = 1'b0;
			pts_acc = 33'd0;
			hdr_len = 8'd0;
			pay_ofs = 8'd0;
			hdr_flags = 8'd0;
		end else if (p == 1) begin
			hdr_flags = b & 8'h5f;
		end else if (p == 2) begin
			pid = {hdr_flags[4:0], b};
			pkt_keep = (pid == pid_model);
		end else if (p == 3) begin
			if (!b[4]) begin
				pkt_keep = 1'b0;
			end
			hdr_flags = (hdr_flags & 8'h40) | (b & 8'h20);
			pay_ofs = 8'd4;
		end else if (p == 4 && hdr_flags[FLAG_ADAPT]) begin
			// Adaptation field that runs to or past the packet end drops the packet.
			if (5 + b >= PKT_BYTES) begin
				pkt_keep = 1'b0;
				pay_ofs = PKT_LAST;
			end else begin
				pay_ofs = 8'(5 + b);
			end
		end else if (pkt_keep && p >= pay_ofs) begin
			k = p - pay_ofs;
			if (!hdr_flags[FLAG_START]) begin
				if (unit_is_open) begin
					push_result(KIND_PAYLOAD, b, 33'd0, 1'b0);
				end
			end else if (k == 0) begin
				if (pay_ofs > PES_OFS_MAX || b != 8'h00) begin
					pkt_keep = 1'b0;
				end
			end else if (k == 1) begin
				if (b != 8'h00) begin
					pkt_keep = 1'b0;
				end
			end else if (k == 2) begin
				if (b != 8'h01) begin
					pkt_keep = 1'b0;
				end else begin
					pes_ok = 1'b1;
					push_result(KIND_START, 8'd0, 33'd0, unit_is_open);
					unit_is_open = 1'b1;
				end
			end else if (pes_ok) begin
				// Header fields: flags, header length and the five PTS bytes.
				case (k)
					7: has_pts = b[7];
					8: hdr_len = b;
					9: pts_acc = 33'(b & 8'h0e) << 29;
					10: pts_acc = pts_acc | (33'(b) << 22);
					11: pts_acc = pts_acc | (33'(b & 8'hfe) << 14);
					12: pts_acc = pts_acc | (33'(b) << 7);
					13: pts_acc = pts_acc | 33'(b >> 1);
					default: ;
				endcase
				if (k >= 9 && k - 9 >= hdr_len) begin
					push_result(KIND_PAYLOAD, b, 33'd0, 1'b0);
				end
				if (k == 13) begin
					push_result(KIND_PTS, 8'd0, has_pts ? pts_acc : 33'd0, 1'b0);
				end
			end
		end
	endtask

	// Input side: predicts on every accepted item, then offers the next one.
	always @(posedge clk) begin : feed_driver
		ts_item_t nxt;
		if (s_tvalid && s_tready) begin
			demux_predict(s_tuser, s_tdata);
		end
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (byte_feed.size() != 0 && (steady || $urandom_range(99) >= 12)) begin
				nxt = byte_feed.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= nxt.data;
				s_tuser <= nxt.cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result side: random back-pressure and the scoreboard.
	always @(posedge clk) begin : result_monitor
		res_t want;
		if (arst_n) begin
			m_tready <= steady || ($urandom_range(99) >= 12);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				report_mismatch("result item with nothing expected", {m_tuser, m_tdata}, 0);
			end else begin
				want = due_results.pop_front();
				if (m_tuser != want.kind) begin
					report_mismatch("kind", m_tuser, want.kind);
				end
				if (m_tdata[7:0] != want.payload_byte) begin
					report_mismatch("payload_byte", m_tdata[7:0], want.payload_byte);
				end
				if (m_tdata[40:8] != want.timestamp) begin
					report_mismatch("timestamp", m_tdata[40:8], want.timestamp);
				end
				if (m_tdata[41] != want.previous_complete) begin
					report_mismatch("previous_complete", m_tdata[41], want.previous_complete);
				end
				if (m_tdata[47:42] != 6'd0) begin
					report_mismatch("tdata padding", m_tdata[47:42], 0);
				end
			end
		end
	end

	// Watchdog: cycles in which no channel moves an item.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Fills pkt_bytes with one packet; adapt_len below zero means no adaptation
	// field, fault 1..3 corrupts that byte of the PES start code.
	task automatic build_packet(input logic [12:0] pid, input logic start,
			input logic carries, input int adapt_len, input int fault,
			input logic pts_flag, input logic [7:0] hlen);
		int ofs;
		for (int i = 0; i < PKT_BYTES; i++) begin
			pkt_bytes[i] = 8'($urandom);
		end
		pkt_bytes[0] = SYNC_BYTE;
		pkt_bytes[1] = {pkt_bytes[1][7], start, pkt_bytes[1][5], pid[12:8]};
		pkt_bytes[2] = pid[7:0];
		pkt_bytes[3] = {pkt_bytes[3][7:6], adapt_len >= 0, carries, pkt_bytes[3][3:0]};
		ofs = 4;
		if (adapt_len >= 0) begin
			pkt_bytes[4] = 8'(adapt_len);
			ofs = 5 + adapt_len;
		end
		if (start) begin
			for (int i = 0; i < 3; i++) begin
				if (ofs + i < PKT_BYTES) begin
					pkt_bytes[ofs + i] = (i == 2) ? 8'h01 : 8'h00;
				end
			end
			if (fault > 0 && ofs + fault - 1 < PKT_BYTES) begin
				pkt_bytes[ofs + fault - 1] ^= 8'(1 << $urandom_range(7));
			end
			if (ofs + 7 < PKT_BYTES) begin
				pkt_bytes[ofs + 7][7] = pts_flag;
			end
			if (ofs + 8 < PKT_BYTES) begin
				pkt_bytes[ofs + 8] = hlen;
			end
		end
	endtask

	task automatic push_bytes(input int first, input int last);
		for (int i = first; i <= last; i++) begin
			byte_feed.push_back('{cmd: CMD_BYTE, data: pkt_bytes[i]});
		end
	endtask

	task automatic queue_packet(input logic [12:0] pid, input logic start,
			input logic carries, input int adapt_len, input int fault,
			input logic pts_flag, input logic [7:0] hlen);
		build_packet(pid, start, carries, adapt_len, fault, pts_flag, hlen);
		push_bytes(0, PKT_BYTES - 1);
	endtask

	// Mostly well-formed packets of the current PID, with some noise.
	task automatic queue_random_packet();
		logic [12:0] pid;
		int alen;
		int fault;
		logic [7:0] hlen;
		pid = ($urandom_range(99) < 85) ? pid_model : 13'($urandom);
		alen = -1;
		case ($urandom_range(9))
			0, 1: alen = $urandom_range(20);
			2: alen = $urandom_range(255);
			default: ;
		endcase
		fault = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
		case ($urandom_range(4))
			0, 1: hlen = 8'($urandom_range(4));
			2, 3: hlen = 8'($urandom_range(5, 12));
			default: hlen = 8'($urandom);
		endcase
		queue_packet(pid, $urandom_range(99) < 35, $urandom_range(19) != 0, alen, fault,
			$urandom_range(9) < 7, hlen);
	endtask

	// Waits until all items are taken, all results delivered and the core settled.
	task automatic wait_idle();
		while (byte_feed.size() != 0 || s_tvalid) begin
			@(posedge clk);
		end
		while (due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pid(input logic [12:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pid_model = value;
	endtask

	initial begin
		logic [12:0] pid;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset PID: continuation before any unit, then unit handling cases.
		queue_packet(PID_RESET, 1'b0, 1'b1, -1, 0, 1'b0, 8'd0);
		queue_packet(PID_RESET, 1'b1, 1'b1, -1, 0, 1'b1, 8'd5);
		// Smallest header length at the last offset that still leaves room.
		queue_packet(PID_RESET, 1'b1, 1'b1, 169, 0, 1'b1, 8'd0);
		// Bad start code leaves the open unit open for the next continuation.
		queue_packet(PID_RESET, 1'b1, 1'b1, -1, 3, 1'b1, 8'd5);
		queue_packet(PID_RESET, 1'b0, 1'b1, 0, 0, 1'b0, 8'd0);

		// PID rewritten after the first two bytes of a packet.
		pid = 13'($urandom);
		build_packet(pid, 1'b1, 1'b1, -1, 0, 1'b1, 8'd3);
		push_bytes(0, 1);
		wait_idle();
		write_pid(pid);
		push_bytes(2, PKT_BYTES - 1);

		// PID extremes, the second phase without any idling.
		for (int ph = 0; ph < 2; ph++) begin
			wait_idle();
			write_pid((ph == 0) ? 13'd0 : 13'h1fff);
			steady <= (ph == 1);
			if (ph == 0) begin
				queue_random_packet();
			end else begin
				queue_packet(pid_model, 1'b1, 1'b1, -1, 0, 1'b1, 8'($urandom_range(8)));
			end
		end

		// Close the stream by a truncated packet and end command, or a bad sync.
		wait_idle();
		steady <= 1'b0;
		build_packet(pid_model, 1'b1, 1'b1, -1, 0, 1'b1, 8'($urandom_range(4)));
		if ($urandom_range(1) == 0) begin
			push_bytes(0, $urandom_range(20, 100));
			byte_feed.push_back('{cmd: CMD_END, data: 8'($urandom)});
		end else begin
			push_bytes(0, PKT_BYTES - 1);
			byte_feed.push_back('{cmd: CMD_BYTE, data: SYNC_BYTE ^ 8'($urandom_range(1, 255))});
		end
		// After the stop nothing may come out, not even for an end command.
		byte_feed.push_back('{cmd: CMD_BYTE, data: SYNC_BYTE});
		repeat (8) byte_feed.push_back('{cmd: CMD_BYTE, data: 8'($urandom)});
		byte_feed.push_back('{cmd: CMD_END, data: 8'($urandom)});
		byte_feed.push_back('{cmd: CMD_BYTE, data: 8'($urandom)});
		wait_idle();

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/tspd_pkg.sv
hw/rtl/tspd_res_fifo.sv
hw/rtl/ts_video_pid_pes_demux_core.sv
hw/rtl/tspd_checker.sv
tb/tb_ts_video_pid_pes_demux_core.sv
